### rtl/core/scflc_pkg.sv
// Shared sizes, field widths and codes of the size-class free-list cache.
// No dependencies; imported by the cache top level and the testbench.
`default_nettype none

package scflc_pkg;

    // Sizing of the cache.
    localparam int SIZE_CLASSES = 8;
    localparam int POOL_DEPTH   = 64;
    localparam int ADDR_BITS    = 48;
    localparam int MAX_DRAIN    = 64;

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 3;
    localparam int SIZE_W     = 32;
    localparam int SHIFT_W    = 5;
    localparam int STACKS_W   = 7;
    localparam int BYTES_W    = 40;
    localparam int TOTAL_W    = 41;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // Derived widths.
    localparam int NODE_AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int IDX_W   = $clog2(POOL_DEPTH + 1);
    localparam int CLS_W   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int K_W     = $clog2(MAX_DRAIN + 1);
    localparam int DATA_W  = ((SIZE_W + ADDR_BITS + 7) / 8) * 8;

    // A node index one past the pool marks the end of a list.
    typedef logic [IDX_W-1:0] idx_t;
    localparam idx_t NULL_IDX = idx_t'(POOL_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_DRAIN = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ALLOC_HIT   = 3'd0,
        STAT_ALLOC_MISS  = 3'd1,
        STAT_FREED       = 3'd2,
        STAT_FREE_FWD    = 3'd3,
        STAT_FREE_IGNORE = 3'd4,
        STAT_DRAIN_ITEM  = 3'd5,
        STAT_DRAIN_EMPTY = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SHIFT = 2'd0,
        CFG_MAX_STACKS = 2'd1,
        CFG_MAX_BYTES  = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

### rtl/core/size_class_free_list_cache.sv
// Size-class free-list cache: per-class LIFO lists threaded through a node pool.
// Depends on scflc_pkg for sizes, widths and codes.
//
//   Channel   Direction  Beat contents
//   s_        in         tuser: command; tdata: block_size, block_base
//   m_        out        tuser: status; tdata: out_base, out_size; tlast: last
//   cfg_      in         cfg_index: register index; cfg_data: value
//
// An allocate or a free reads the node pool in its accept cycle; the run state
// then writes the pool back and loads the output register.
// A drain enters the drain state, then takes each cached block with one node
// pool read and one write-back, or gives one empty beat for an empty cache.
// Reset is immediate: the spare chain of the next-pointer store comes from
// per-node valid bits, so there is no clearing pass. A stalled m_ side holds
// the block in its write-back cycle; configuration beats are taken every cycle.
`default_nettype none

module size_class_free_list_cache (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // block_size, block_base
    input  logic [scflc_pkg::DATA_W-1:0]      s_tdata,
    // command
    input  logic [scflc_pkg::CMD_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_base, out_size
    output logic [scflc_pkg::DATA_W-1:0]      m_tdata,
    // status
    output logic [scflc_pkg::STAT_W-1:0]      m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scflc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scflc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import scflc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SHIFT_W-1:0]  page_shift_reg;
    logic [STACKS_W-1:0] max_stacks_reg;
    logic [BYTES_W-1:0]  max_bytes_reg;

    // Class table and counters.
    logic [SIZE_W-1:0]   class_size_reg [SIZE_CLASSES];
    logic [SIZE_W-1:0]   class_size_next [SIZE_CLASSES];
    idx_t                class_head_reg [SIZE_CLASSES];
    idx_t                class_head_next [SIZE_CLASSES];
    idx_t                spare_head_reg, spare_head_next;
    logic [STACKS_W-1:0] cached_blocks_reg, cached_blocks_next;
    logic [TOTAL_W-1:0]  cached_bytes_reg, cached_bytes_next;

    // Operation in flight.
    status_t             op_stat_reg, op_stat_next;
    logic [CLS_W-1:0]    op_slot_reg, op_slot_next;
    logic [ADDR_BITS-1:0] op_base_reg, op_base_next;
    logic [SIZE_W-1:0]   op_size_reg, op_size_next;
    logic [NODE_AW-1:0]  op_node_reg, op_node_next;
    logic                op_claim_reg, op_claim_next;
    logic [K_W-1:0]      drain_k_reg, drain_k_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    status_t             m_stat_reg, m_stat_next;
    logic [ADDR_BITS-1:0] m_base_reg, m_base_next;
    logic [SIZE_W-1:0]   m_size_reg, m_size_next;
    logic                m_last_reg, m_last_next;

    // Node pool memories and their read and write ports.
    logic [ADDR_BITS-1:0] node_base_mem [POOL_DEPTH];
    idx_t                 node_next_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] next_vld_reg;
    logic [ADDR_BITS-1:0] base_rd_reg;
    idx_t                 next_raw_reg;
    logic                 next_vld_rd_reg;
    logic [NODE_AW-1:0]   rd_addr_reg;
    logic                 mem_rd_en;
    logic [NODE_AW-1:0]   mem_rd_addr;
    logic                 base_wr_en;
    logic                 next_wr_en;
    logic [NODE_AW-1:0]   mem_wr_addr;
    idx_t                 next_wr_data;
    idx_t                 next_rd;

    // Input fields.
    logic [SIZE_W-1:0]    in_size;
    logic [ADDR_BITS-1:0] in_base;
    logic [SIZE_W-1:0]    page_mask;
    logic [SIZE_W-1:0]    rounded;

    // Class searches.
    logic                 hit_any, same_any, free_any, drain_any, other_any;
    logic [CLS_W-1:0]     hit_idx, same_idx, free_idx, drain_idx;
    logic                 fits, spare_ok, out_free, drain_last;

    assign in_size = s_tdata[SIZE_W-1:0];
    assign in_base = s_tdata[SIZE_W +: ADDR_BITS];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_stat_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = DATA_W'({m_size_reg, m_base_reg});

    // Round the request up to a whole page, modulo 2^32.
    assign page_mask = (SIZE_W'(1) << page_shift_reg) - SIZE_W'(1);
    assign rounded   = (in_size + page_mask) & ~page_mask;

    // Admission limits for a free.
    assign fits = (cached_blocks_reg < max_stacks_reg) &&
                  (({1'b0, cached_bytes_reg} + (TOTAL_W + 1)'(in_size)) <=
                   (TOTAL_W + 1)'(max_bytes_reg));
    assign spare_ok = (spare_head_reg != NULL_IDX);

    // Priority searches over the class table; the lowest slot wins.
    always_comb begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        same_any  = 1'b0;
        same_idx  = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        drain_any = 1'b0;
        drain_idx = '0;
        other_any = 1'b0;
        for (int c = 0; c < SIZE_CLASSES; c++) begin
            if (!hit_any && class_size_reg[c] != '0 && class_size_reg[c] == rounded) begin
                hit_any = 1'b1;
                hit_idx = CLS_W'(c);
            end
            if (!same_any && class_size_reg[c] == in_size) begin
                same_any = 1'b1;
                same_idx = CLS_W'(c);
            end
            if (!free_any && class_size_reg[c] == '0) begin
                free_any = 1'b1;
                free_idx = CLS_W'(c);
            end
            if (!drain_any && class_head_reg[c] != NULL_IDX) begin
                drain_any = 1'b1;
                drain_idx = CLS_W'(c);
            end
            if (CLS_W'(c) != op_slot_reg && class_head_reg[c] != NULL_IDX) begin
                other_any = 1'b1;
            end
        end
    end

    // A never-written next pointer reads as the initial spare chain.
    assign next_rd = next_vld_rd_reg ? next_raw_reg : (idx_t'(rd_addr_reg) + idx_t'(1));

    // The drained block is the final one when nothing is left behind it, or when it is the MAX_DRAIN-th of the drain.
    assign drain_last = ((next_rd == NULL_IDX) && !other_any) ||
                        (drain_k_reg == K_W'(MAX_DRAIN - 1));

    assign out_free = !m_valid_reg || m_tready;

    // Sequencer: reads happen in idle and drain cycles, writes in run cycles,
    // so the node pool never sees a read and a write in the same cycle.
    always_comb begin
        state_next         = state_reg;
        class_size_next    = class_size_reg;
        class_head_next    = class_head_reg;
        spare_head_next    = spare_head_reg;
        cached_blocks_next = cached_blocks_reg;
        cached_bytes_next  = cached_bytes_reg;
        op_stat_next       = op_stat_reg;
        op_slot_next       = op_slot_reg;
        op_base_next       = op_base_reg;
        op_size_next       = op_size_reg;
        op_node_next       = op_node_reg;
        op_claim_next      = op_claim_reg;
        drain_k_next       = drain_k_reg;
        m_valid_next       = m_valid_reg && !m_tready;
        m_stat_next        = m_stat_reg;
        m_base_next        = m_base_reg;
        m_size_next        = m_size_reg;
        m_last_next        = m_last_reg;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = op_node_reg;
        base_wr_en         = 1'b0;
        next_wr_en         = 1'b0;
        mem_wr_addr        = op_node_reg;
        next_wr_data       = spare_head_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (cmd_t'(s_tuser))
                        CMD_ALLOC: begin
                            op_size_next = rounded;
                            op_base_next = '0;
                            op_slot_next = hit_idx;
                            op_node_next = class_head_reg[hit_idx][NODE_AW-1:0];
                            state_next   = S_RUN;
                            if (hit_any && class_head_reg[hit_idx] != NULL_IDX) begin
                                op_stat_next = STAT_ALLOC_HIT;
                                mem_rd_en    = 1'b1;
                                mem_rd_addr  = class_head_reg[hit_idx][NODE_AW-1:0];
                            end else begin
                                op_stat_next = STAT_ALLOC_MISS;
                            end
                        end
                        CMD_FREE: begin
                            op_size_next  = in_size;
                            op_base_next  = in_base;
                            op_node_next  = spare_head_reg[NODE_AW-1:0];
                            op_claim_next = 1'b0;
                            state_next    = S_RUN;
                            if (in_size == '0 || in_base == '0) begin
                                op_stat_next = STAT_FREE_IGNORE;
                            end else if (!fits || !spare_ok) begin
                                op_stat_next = STAT_FREE_FWD;
                            end else if (same_any) begin
                                op_stat_next = STAT_FREED;
                                op_slot_next = same_idx;
                                mem_rd_en    = 1'b1;
                                mem_rd_addr  = spare_head_reg[NODE_AW-1:0];
                            end else if (free_any) begin
                                op_stat_next  = STAT_FREED;
                                op_slot_next  = free_idx;
                                op_claim_next = 1'b1;
                                mem_rd_en     = 1'b1;
                                mem_rd_addr   = spare_head_reg[NODE_AW-1:0];
                            end else begin
                                op_stat_next = STAT_FREE_FWD;
                            end
                        end
                        CMD_DRAIN: begin
                            drain_k_next = '0;
                            state_next   = S_DRAIN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DRAIN: begin
                if (drain_any) begin
                    // Read the newest node of the lowest non-empty slot.
                    op_stat_next = STAT_DRAIN_ITEM;
                    op_slot_next = drain_idx;
                    op_size_next = class_size_reg[drain_idx];
                    op_node_next = class_head_reg[drain_idx][NODE_AW-1:0];
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = class_head_reg[drain_idx][NODE_AW-1:0];
                    state_next   = S_RUN;
                end else if (out_free) begin
                    // Nothing cached at all.
                    m_valid_next = 1'b1;
                    m_stat_next  = STAT_DRAIN_EMPTY;
                    m_base_next  = '0;
                    m_size_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_RUN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_stat_next  = op_stat_reg;
                    m_base_next  = op_base_reg;
                    m_size_next  = op_size_reg;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                    case (op_stat_reg)
                        STAT_ALLOC_HIT, STAT_DRAIN_ITEM: begin
                            // Pop the head node and return it to the spare list.
                            m_base_next                  = base_rd_reg;
                            class_head_next[op_slot_reg] = next_rd;
                            next_wr_en                   = 1'b1;
                            next_wr_data                 = spare_head_reg;
                            spare_head_next              = idx_t'(op_node_reg);
                            cached_blocks_next = cached_blocks_reg - STACKS_W'(1);
                            cached_bytes_next  = cached_bytes_reg -
                                                 TOTAL_W'(class_size_reg[op_slot_reg]);
                            if (op_stat_reg == STAT_DRAIN_ITEM) begin
                                m_last_next  = drain_last;
                                drain_k_next = drain_k_reg + K_W'(1);
                                state_next   = drain_last ? S_IDLE : S_DRAIN;
                            end
                        end
                        STAT_FREED: begin
                            // Push the spare head node onto the class list.
                            spare_head_next              = next_rd;
                            base_wr_en                   = 1'b1;
                            next_wr_en                   = 1'b1;
                            next_wr_data                 = class_head_reg[op_slot_reg];
                            class_head_next[op_slot_reg] = idx_t'(op_node_reg);
                            if (op_claim_reg) begin
                                class_size_next[op_slot_reg] = op_size_reg;
                            end
                            cached_blocks_next = cached_blocks_reg + STACKS_W'(1);
                            cached_bytes_next  = cached_bytes_reg + TOTAL_W'(op_size_reg);
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            spare_head_reg    <= '0;
            cached_blocks_reg <= '0;
            cached_bytes_reg  <= '0;
            m_valid_reg       <= 1'b0;
            for (int c = 0; c < SIZE_CLASSES; c++) begin
                class_size_reg[c] <= '0;
                class_head_reg[c] <= NULL_IDX;
            end
        end else begin
            state_reg         <= state_next;
            spare_head_reg    <= spare_head_next;
            cached_blocks_reg <= cached_blocks_next;
            cached_bytes_reg  <= cached_bytes_next;
            m_valid_reg       <= m_valid_next;
            class_size_reg    <= class_size_next;
            class_head_reg    <= class_head_next;
        end
    end

    // Operation and output payload registers.
    always_ff @(posedge aclk) begin
        op_stat_reg  <= op_stat_next;
        op_slot_reg  <= op_slot_next;
        op_base_reg  <= op_base_next;
        op_size_reg  <= op_size_next;
        op_node_reg  <= op_node_next;
        op_claim_reg <= op_claim_next;
        drain_k_reg  <= drain_k_next;
        m_stat_reg   <= m_stat_next;
        m_base_reg   <= m_base_next;
        m_size_reg   <= m_size_next;
        m_last_reg   <= m_last_next;
    end

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= SHIFT_W'(12);
            max_stacks_reg <= STACKS_W'(64);
            max_bytes_reg  <= BYTES_W'(16777216);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAGE_SHIFT: page_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_MAX_STACKS: max_stacks_reg <= cfg_data[STACKS_W-1:0];
                CFG_MAX_BYTES:  max_bytes_reg  <= cfg_data[BYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the next-pointer store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_vld_reg <= '0;
        end else if (next_wr_en) begin
            next_vld_reg[mem_wr_addr] <= 1'b1;
        end
    end

    // Node pool memories with registered read data.
    always_ff @(posedge aclk) begin
        if (base_wr_en) begin
            node_base_mem[mem_wr_addr] <= op_base_reg;
        end
        if (next_wr_en) begin
            node_next_mem[mem_wr_addr] <= next_wr_data;
        end
        if (mem_rd_en) begin
            base_rd_reg     <= node_base_mem[mem_rd_addr];
            next_raw_reg    <= node_next_mem[mem_rd_addr];
            next_vld_rd_reg <= next_vld_reg[mem_rd_addr];
            rd_addr_reg     <= mem_rd_addr;
        end
    end

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the size-class free-list cache: a scoreboard class
// predicts every result beat, and plain tasks drive the request and config channels.
// Depends on scflc_pkg and the size_class_free_list_cache top level.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scflc_pkg::*;

    // The command encoding the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        status_t                status;
        logic [ADDR_BITS-1:0]   base;
        logic [SIZE_W-1:0]      size;
        logic                   last;
    } reply_t;

    // Predicts the cache's answers and compares them with the result beats.
    class cache_scoreboard;
        logic [SIZE_W-1:0]      slot_size [SIZE_CLASSES];
        idx_t                   slot_head [SIZE_CLASSES];
        logic [STACKS_W-1:0]    slot_count [SIZE_CLASSES];
        logic [ADDR_BITS-1:0]   node_addr [POOL_DEPTH];
        idx_t                   node_link [POOL_DEPTH];
        idx_t                   spare_node;
        logic [STACKS_W-1:0]    held_blocks;
        logic [TOTAL_W-1:0]     held_bytes;
        logic [SHIFT_W-1:0]     page_shift;
        logic [STACKS_W-1:0]    max_blocks;
        logic [BYTES_W-1:0]     max_bytes;
        reply_t                 pending_replies [$];
        int                     errors;

        function new();
            page_shift  = 5'd12;
            max_blocks  = 7'd64;
            max_bytes   = 40'd16777216;
            for (int c = 0; c < SIZE_CLASSES; c++) begin
                slot_size[c]  = '0;
                slot_head[c]  = NULL_IDX;
                slot_count[c] = '0;
            end
            // Every node starts on the spare chain, in index order.
            for (int n = 0; n < POOL_DEPTH; n++) begin
                node_addr[n] = '0;
                node_link[n] = idx_t'(n + 1);
            end
            spare_node  = '0;
            held_blocks = '0;
            held_bytes  = '0;
            errors      = 0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PAGE_SHIFT: page_shift = value[SHIFT_W-1:0];
                CFG_MAX_STACKS: max_blocks = value[STACKS_W-1:0];
                CFG_MAX_BYTES:  max_bytes  = value[BYTES_W-1:0];
                default: ;
            endcase
        endfunction

        function void expect_reply(status_t status, logic [ADDR_BITS-1:0] base,
                                   logic [SIZE_W-1:0] size, logic last);
            reply_t r;
            r.status = status;
            r.base   = base;
            r.size   = size;
            r.last   = last;
            pending_replies = {pending_replies, r};
        endfunction

        // Slot holding the given size, or -1; a zero size finds an unclaimed slot.
        function int find_slot(logic [SIZE_W-1:0] size);
            for (int c = 0; c < SIZE_CLASSES; c++) begin
                if (slot_size[c] == size) return c;
            end
            return -1;
        endfunction

        // Unlinks the newest block of a non-empty slot and recycles its node.
        function logic [ADDR_BITS-1:0] pop_newest(int c);
            logic [NODE_AW-1:0] n;
            n = slot_head[c][NODE_AW-1:0];
            slot_head[c] = node_link[n];
            node_link[n] = spare_node;
            spare_node = idx_t'(n);
            slot_count[c]--;
            held_blocks--;
            held_bytes -= TOTAL_W'(slot_size[c]);
            return node_addr[n];
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                                   logic [ADDR_BITS-1:0] base);
            logic [63:0]        mask;
            logic [SIZE_W-1:0]  rounded;
            logic [NODE_AW-1:0] n;
            int                 slot;
            int                 emitted;
            case (cmd)
                CMD_ALLOC: begin
                    // Round up to a whole page; the sum wraps at 32 bits.
                    mask = (64'd1 << page_shift) - 64'd1;
                    rounded = SIZE_W'((64'(size) + mask) & ~mask);
                    slot = (rounded == '0) ? -1 : find_slot(rounded);
                    if (slot >= 0 && slot_head[slot] != NULL_IDX) begin
                        expect_reply(STAT_ALLOC_HIT, pop_newest(slot), rounded, 1'b1);
                    end else begin
                        expect_reply(STAT_ALLOC_MISS, '0, rounded, 1'b1);
                    end
                end
                CMD_FREE: begin
                    if (size == '0 || base == '0) begin
                        expect_reply(STAT_FREE_IGNORE, base, size, 1'b1);
                    end else if (!(held_blocks < max_blocks &&
                                   64'(held_bytes) + 64'(size) <= 64'(max_bytes)) ||
                                 spare_node == NULL_IDX) begin
                        expect_reply(STAT_FREE_FWD, base, size, 1'b1);
                    end else begin
                        slot = find_slot(size);
                        if (slot < 0) begin
                            slot = find_slot('0);
                            if (slot >= 0) slot_size[slot] = size;
                        end
                        if (slot < 0) begin
                            expect_reply(STAT_FREE_FWD, base, size, 1'b1);
                        end else begin
                            // Take a spare node and push it on the slot's list.
                            n = spare_node[NODE_AW-1:0];
                            spare_node = node_link[n];
                            node_addr[n] = base;
                            node_link[n] = slot_head[slot];
                            slot_head[slot] = idx_t'(n);
                            slot_count[slot]++;
                            held_blocks++;
                            held_bytes += TOTAL_W'(size);
                            expect_reply(STAT_FREED, base, size, 1'b1);
                        end
                    end
                end
                CMD_DRAIN: begin
                    emitted = 0;
                    for (int c = 0; c < SIZE_CLASSES && emitted < MAX_DRAIN; c++) begin
                        while (slot_head[c] != NULL_IDX && emitted < MAX_DRAIN) begin
                            expect_reply(STAT_DRAIN_ITEM, pop_newest(c), slot_size[c], 1'b0);
                            emitted++;
                        end
                    end
                    if (emitted == 0) begin
                        expect_reply(STAT_DRAIN_EMPTY, '0, '0, 1'b1);
                    end else begin
                        pending_replies[$].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_reply(logic [STAT_W-1:0] status, logic [ADDR_BITS-1:0] base,
                                  logic [SIZE_W-1:0] size, logic last);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $error("result beat with nothing expected: status %0d base 0x%0h size 0x%0h",
                       status, base, size);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (base !== want.base) begin
                $error("out_base: expected 0x%0h, actual 0x%0h", want.base, base);
                errors++;
            end
            if (size !== want.size) begin
                $error("out_size: expected 0x%0h, actual 0x%0h", want.size, size);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata = '0;   // block_size, block_base
    logic [CMD_W-1:0]       s_tuser = '0;   // command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DATA_W-1:0]      m_tdata;        // out_base, out_size
    logic [STAT_W-1:0]      m_tuser;        // status
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cache_scoreboard        sb = new();
    logic [SHIFT_W-1:0]     cur_shift = 5'd12;
    int                     burst_left = 0;
    int                     quiet_cycles = 0;
    bit                     hold_off = 1'b0;

    size_class_free_list_cache u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Observe every beat on all three channels at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_register(cfg_idx_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata[SIZE_W-1:0], s_tdata[SIZE_W +: ADDR_BITS]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_reply(m_tuser, m_tdata[ADDR_BITS-1:0], m_tdata[ADDR_BITS +: SIZE_W],
                               m_tlast);
            end
        end
    end

    // Give up when no channel has moved a beat for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("size_class_free_list_cache test failed");
                $finish;
            end
        end
    end

    // Result side: random stall patterns take turns; a requested hold-off keeps
    // m_tready low long enough to back up the request side.
    initial begin
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (tick % 4) != 3;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    // Sizes that claim the class slots; most traffic reuses them.
    function automatic logic [SIZE_W-1:0] menu_size(int i);
        case (i)
            0: return 32'd1;
            1: return 32'd4096;
            2: return 32'd8192;
            3: return 32'd12288;
            4: return 32'd65536;
            5: return 32'd1 << 20;
            6: return 32'd1 << 24;
            default: return 32'hFFFF_F000;
        endcase
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_base();
        logic [ADDR_BITS-1:0] base;
        base = ADDR_BITS'({$urandom, $urandom});
        if (base == '0) base = ADDR_BITS'(1);
        return base;
    endfunction

    // An allocate request less than a page below the class size; it rounds up to it when that is whole pages.
    function automatic logic [SIZE_W-1:0] request_for(logic [SIZE_W-1:0] cls);
        logic [63:0] page;
        logic [63:0] off;
        page = 64'd1 << cur_shift;
        off = 64'($urandom) % page;
        if (off >= 64'(cls)) off = '0;
        return SIZE_W'(64'(cls) - off);
    endfunction

    // One request beat; the sender runs in bursts with random gaps between them.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                                logic [ADDR_BITS-1:0] base);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {base, size};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(logic [SHIFT_W-1:0] shift, logic [STACKS_W-1:0] stacks,
                             logic [BYTES_W-1:0] bytes);
        write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_MAX_STACKS, CFG_DATA_W'(stacks));
        write_reg(CFG_MAX_BYTES, CFG_DATA_W'(bytes));
        cfg_valid <= 1'b0;
        cur_shift = shift;
    endtask

    // Stop sending, collect every outstanding result, then idle before the next register write.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Field extremes, every command and status, and the corner cases.
    task automatic directed_checks();
        send_request(CMD_DRAIN, '0, '0);
        for (int i = 0; i < SIZE_CLASSES; i++) send_request(CMD_FREE, menu_size(i), random_base());
        send_request(CMD_FREE, '0, random_base());
        send_request(CMD_FREE, 32'h1000, '0);
        // All slots are claimed now, so a new size has nowhere to go.
        send_request(CMD_FREE, '1, '1);
        send_request(CMD_ALLOC, 32'd1, '0);
        send_request(CMD_ALLOC, 32'd4096, '1);
        // These two round past the top of the size range and wrap to zero.
        send_request(CMD_ALLOC, '1, random_base());
        send_request(CMD_ALLOC, 32'hFFFF_F001, random_base());
        send_request(CMD_ALLOC, '0, random_base());
        send_request(CMD_ALLOC, 32'hFFFF_E001, random_base());
        send_request(CMD_UNUSED, '1, '1);
        send_request(CMD_FREE, 32'h2000, '1);
        send_request(CMD_DRAIN, '1, '1);
        send_request(CMD_DRAIN, '0, '0);
    endtask

    // Frees more blocks than the pool holds, then drains the full pool at once.
    task automatic fill_and_drain(int count);
        for (int i = 0; i < count; i++) begin
            send_request(CMD_FREE, menu_size($urandom_range(0, 2)), random_base());
        end
        send_request(CMD_DRAIN, '0, '0);
    endtask

    // Mostly well-formed frees and matching allocates, with some noise.
    task automatic random_phase(int count);
        int                     done;
        int                     pick;
        logic [SIZE_W-1:0]      cls;
        logic [ADDR_BITS-1:0]   base;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            cls  = menu_size($urandom_range(0, SIZE_CLASSES - 1));
            base = random_base();
            if (pick < 42) begin
                send_request(CMD_FREE, cls, base);
            end else if (pick < 45) begin
                if ($urandom_range(0, 1) != 0) send_request(CMD_FREE, '0, base);
                else send_request(CMD_FREE, cls, '0);
            end else if (pick < 83) begin
                send_request(CMD_ALLOC, request_for(cls), base);
            end else if (pick < 89) begin
                send_request(CMD_ALLOC, $urandom, base);
            end else if (pick < 94) begin
                send_request(CMD_FREE, $urandom, base);
            end else if (pick < 98) begin
                send_request(CMD_DRAIN, $urandom, base);
            end else begin
                send_request(CMD_UNUSED, $urandom, base);
            end
            if (pick < 98) done++;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        configure(5'd12, 7'd64, BYTES_MAX);
        directed_checks();
        random_phase(40);
        settle();

        // Smallest page; the result side backs up while the pool fills.
        configure(5'd0, 7'd64, BYTES_MAX);
        hold_off = 1'b1;
        fill_and_drain(70);
        random_phase(40);
        settle();

        // A 16 MiB page and zero limits: every well-formed free is forwarded.
        configure(5'd24, 7'd0, '0);
        random_phase(25);
        settle();

        // Tight count and byte limits.
        configure(5'd4, 7'd5, 40'd70000);
        random_phase(40);
        settle();

        configure(5'd12, 7'd64, 40'd16777216);
        random_phase(40);
        send_request(CMD_DRAIN, '0, '0);
        settle();

        if (sb.errors == 0) begin
            $display("size_class_free_list_cache test passed");
        end else begin
            $display("size_class_free_list_cache test failed");
        end
        $finish;
    end

endmodule
